### rtl/smca_pkg.sv
// shared types and constants for the sparse coordinate-list adder
`default_nettype none

package smca_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int INDEX_BITS_DEF = 8;
  localparam int COORD_W        = 8;
  localparam int VALUE_W        = 32;
  localparam int CMD_DEPTH      = 2;
  localparam int OUT_DEPTH      = 2;

  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_RUN    = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_RUN    = 2'd2
  } op_t;

  typedef struct packed {
    logic [COORD_W-1:0]        row;
    logic [COORD_W-1:0]        col;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    op_t    op;
    entry_t entry;
  } cmd_t;

  typedef struct packed {
    entry_t entry;
    logic   is_last;
    logic   is_empty;
    logic   overflowed;
  } res_t;

endpackage

`default_nettype wire

### rtl/smca_fifo.sv
// small register queue used for commands and for results
`default_nettype none

module smca_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r;
  logic [PtrW-1:0]  rd_ptr_r;
  logic [CntW-1:0]  cnt_r;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt_r == CntW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### rtl/smca_front.sv
// input side: decodes the function code and masks coordinates into a command
`default_nettype none

module smca_front
  import smca_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [1:0]                in_func,
  input  wire logic [COORD_W-1:0]        in_row,
  input  wire logic [COORD_W-1:0]        in_col,
  input  wire logic signed [VALUE_W-1:0] in_value,
  input  wire logic                      cmd_full,
  output logic                           cmd_push,
  output cmd_t                           cmd
);

  localparam int MaskW = (INDEX_BITS < COORD_W) ? INDEX_BITS : COORD_W;
  localparam logic [COORD_W-1:0] IdxMask = COORD_W'((1 << MaskW) - 1);

  logic known;

  always_comb begin
    known           = 1'b1;
    cmd.op          = OP_RUN;
    cmd.entry.row   = in_row & IdxMask;
    cmd.entry.col   = in_col & IdxMask;
    cmd.entry.value = in_value;
    case (in_func)
      FUNC_LOAD_A: cmd.op = OP_LOAD_A;
      FUNC_LOAD_B: cmd.op = OP_LOAD_B;
      FUNC_RUN:    cmd.op = OP_RUN;
      default:     known  = 1'b0;
    endcase
  end

  // unused function code is taken and dropped here
  assign full            = cmd_full;
  assign cmd_push        = push && !cmd_full && known;

endmodule

`default_nettype wire

### rtl/smca_back.sv
// execution side: entry stores, counts, overflow flag and the match scan
`default_nettype none

module smca_back
  import smca_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  input  wire logic res_full,
  output logic      res_push,
  output res_t      res
);

  localparam int AddrW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CntW  = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_NEXT,
    S_CUR,
    S_PREQ,
    S_PCMP,
    S_EMIT,
    S_FIN
  } state_t;

  state_t          state_r;
  entry_t          mem_a [ENTRIES];
  entry_t          mem_b [ENTRIES];
  entry_t          rd_a_r;
  entry_t          rd_b_r;
  logic [CntW-1:0] cnt_a_r;
  logic [CntW-1:0] cnt_b_r;
  logic            ovf_r;
  logic [CntW-1:0] i_r;
  logic [CntW-1:0] j_r;
  logic            phase_b_r;
  logic            probe_b_r;
  entry_t          cur_r;
  entry_t          new_r;
  entry_t          pend_r;
  logic            pend_empty_r;
  logic            pend_v_r;

  logic [CntW-1:0] lim;
  logic [CntW-1:0] rd_idx;
  entry_t          pdata;
  entry_t          cdata;
  logic            hit;
  logic            wr_a;
  logic            wr_b;

  assign cmd_pop = (state_r == S_IDLE) && cmd_valid;
  assign wr_a    = cmd_pop && (cmd.op == OP_LOAD_A) && (cnt_a_r != CntW'(ENTRIES));
  assign wr_b    = cmd_pop && (cmd.op == OP_LOAD_B) && (cnt_b_r != CntW'(ENTRIES));

  // outer entry is fetched by i, probed entries by j
  assign rd_idx = (state_r == S_NEXT) ? i_r : j_r;
  assign lim    = probe_b_r ? (phase_b_r ? i_r : cnt_b_r) : cnt_a_r;
  assign pdata  = probe_b_r ? rd_b_r : rd_a_r;
  assign cdata  = phase_b_r ? rd_b_r : rd_a_r;
  assign hit    = (pdata.row == cur_r.row) && (pdata.col == cur_r.col);

  assign res_push       = !res_full && ((state_r == S_EMIT && pend_v_r) || state_r == S_FIN);
  assign res.entry      = pend_r;
  assign res.is_last    = (state_r == S_FIN);
  assign res.is_empty   = pend_empty_r;
  assign res.overflowed = ovf_r;

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[cnt_a_r[AddrW-1:0]] <= cmd.entry;
    end
    if (wr_b) begin
      mem_b[cnt_b_r[AddrW-1:0]] <= cmd.entry;
    end
    rd_a_r <= mem_a[rd_idx[AddrW-1:0]];
    rd_b_r <= mem_b[rd_idx[AddrW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_a_r  <= '0;
      cnt_b_r  <= '0;
      ovf_r    <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              OP_LOAD_A: begin
                if (wr_a) cnt_a_r <= cnt_a_r + 1'b1;
                else      ovf_r   <= 1'b1;
              end
              OP_LOAD_B: begin
                if (wr_b) cnt_b_r <= cnt_b_r + 1'b1;
                else      ovf_r   <= 1'b1;
              end
              OP_RUN: begin
                i_r       <= '0;
                phase_b_r <= 1'b0;
                if (cnt_a_r == '0 && cnt_b_r == '0) begin
                  pend_r       <= '0;
                  pend_empty_r <= 1'b1;
                  pend_v_r     <= 1'b1;
                  state_r      <= S_FIN;
                end else begin
                  state_r <= S_NEXT;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_NEXT: begin
          if (!phase_b_r && i_r == cnt_a_r) begin
            phase_b_r <= 1'b1;
            i_r       <= '0;
          end else if (phase_b_r && i_r == cnt_b_r) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_CUR;
          end
        end
        S_CUR: begin
          cur_r     <= cdata;
          j_r       <= '0;
          probe_b_r <= !phase_b_r;
          state_r   <= S_PREQ;
        end
        S_PREQ: begin
          if (j_r == lim) begin
            if (phase_b_r && !probe_b_r) begin
              // no a entry there, now earlier b entries
              probe_b_r <= 1'b1;
              j_r       <= '0;
            end else begin
              new_r   <= cur_r;
              state_r <= S_EMIT;
            end
          end else begin
            state_r <= S_PCMP;
          end
        end
        S_PCMP: begin
          if (hit) begin
            if (!phase_b_r) begin
              new_r.row   <= cur_r.row;
              new_r.col   <= cur_r.col;
              new_r.value <= cur_r.value + pdata.value;
              state_r     <= S_EMIT;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_NEXT;
            end
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_PREQ;
          end
        end
        S_EMIT: begin
          // one result is held back so the final one can carry is_last
          if (!pend_v_r || !res_full) begin
            pend_r       <= new_r;
            pend_empty_r <= 1'b0;
            pend_v_r     <= 1'b1;
            i_r          <= i_r + 1'b1;
            state_r      <= S_NEXT;
          end
        end
        S_FIN: begin
          if (!res_full) begin
            pend_v_r <= 1'b0;
            cnt_a_r  <= '0;
            cnt_b_r  <= '0;
            ovf_r    <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/sparse_matrix_coo_add.sv
// top level of the sparse coordinate-list matrix adder
//
//   channel  handshake     payload
//   input    push / full   in_func, in_row, in_col, in_value
//   result   pop / empty   out_row, out_col, out_value, out_is_last,
//                          out_is_empty, out_overflowed
//
// a load is taken in the idle state of the execution side; unused function codes are dropped in the front
// a run checks each a entry against the b store, then each b entry against the a store and
// the earlier b entries, one probe at a time through the single read port of each store
// reset clears counts, overflow flag and both queues; store contents stay undefined
// a full result queue stalls the scan, a busy scan fills the two-deep command queue
`default_nettype none

module sparse_matrix_coo_add
  import smca_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [1:0]                in_func,
  input  wire logic [COORD_W-1:0]        in_row,
  input  wire logic [COORD_W-1:0]        in_col,
  input  wire logic signed [VALUE_W-1:0] in_value,
  output logic                           empty,
  input  wire logic                      pop,
  output logic [COORD_W-1:0]             out_row,
  output logic [COORD_W-1:0]             out_col,
  output logic signed [VALUE_W-1:0]      out_value,
  output logic                           out_is_last,
  output logic                           out_is_empty,
  output logic                           out_overflowed
);

  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_push;
  logic cmd_full;
  logic cmd_empty;
  logic cmd_pop;
  res_t res_in;
  res_t res_head;
  logic res_push;
  logic res_full;

  smca_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .push     (push),
    .full     (full),
    .in_func  (in_func),
    .in_row   (in_row),
    .in_col   (in_col),
    .in_value (in_value),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  smca_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_head),
    .empty   (cmd_empty)
  );

  smca_back #(
    .ENTRIES(ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  smca_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(OUT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_head),
    .empty   (empty)
  );

  assign out_row        = res_head.entry.row;
  assign out_col        = res_head.entry.col;
  assign out_value      = res_head.entry.value;
  assign out_is_last    = res_head.is_last;
  assign out_is_empty   = res_head.is_empty;
  assign out_overflowed = res_head.overflowed;

`ifndef SYNTHESIS
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result beat pushed into a full queue");

  a_cmd_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command beat taken from an empty queue");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_is_empty) |->
      (out_is_last && out_row == '0 && out_col == '0 && out_value == '0))
    else $error("empty-run result is not a zero final beat");
`endif

endmodule

`default_nettype wire

### verif/sparse_matrix_coo_add_test.sv
// self-checking testbench for the sparse coordinate-list matrix adder
module sparse_matrix_coo_add_test;
  import smca_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [COORD_W-1:0] IDX_MASK = COORD_W'((1 << INDEX_BITS_DEF) - 1);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [1:0] in_func = FUNC_LOAD_A;
  logic [COORD_W-1:0] in_row = '0;
  logic [COORD_W-1:0] in_col = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic empty;
  logic pop = 1'b0;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic signed [VALUE_W-1:0] out_value;
  logic out_is_last;
  logic out_is_empty;
  logic out_overflowed;

  // own copy of both coordinate lists
  entry_t list_a [ENTRIES_DEF];
  entry_t list_b [ENTRIES_DEF];
  int count_a = 0;
  int count_b = 0;
  logic dropped = 1'b0;
  entry_t last_a = '0;

  res_t pending_sums [$];
  bit quiet = 1'b0;
  int stall_left = 0;
  int errors = 0;
  int n_items = 0;
  int n_runs = 0;
  int n_checked = 0;

  sparse_matrix_coo_add uut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_func(in_func),
    .in_row(in_row),
    .in_col(in_col),
    .in_value(in_value),
    .empty(empty),
    .pop(pop),
    .out_row(out_row),
    .out_col(out_col),
    .out_value(out_value),
    .out_is_last(out_is_last),
    .out_is_empty(out_is_empty),
    .out_overflowed(out_overflowed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void predict_beat(input logic [1:0] f, input logic [COORD_W-1:0] r,
                                       input logic [COORD_W-1:0] c,
                                       input logic signed [VALUE_W-1:0] v);
    res_t sums [2*ENTRIES_DEF];
    int n;
    entry_t e;
    logic signed [VALUE_W-1:0] add;
    bit found;
    n = 0;
    e.row = r & IDX_MASK;
    e.col = c & IDX_MASK;
    e.value = v;
    case (f)
      FUNC_LOAD_A: begin
        if (count_a >= ENTRIES_DEF) dropped = 1'b1;
        else begin
          list_a[count_a] = e;
          count_a++;
        end
      end
      FUNC_LOAD_B: begin
        if (count_b >= ENTRIES_DEF) dropped = 1'b1;
        else begin
          list_b[count_b] = e;
          count_b++;
        end
      end
      FUNC_RUN: begin
        if (count_a == 0 && count_b == 0) begin
          sums[0] = '0;
          sums[0].is_last = 1'b1;
          sums[0].is_empty = 1'b1;
          sums[0].overflowed = dropped;
          n = 1;
        end else begin
          for (int i = 0; i < count_a; i++) begin
            add = '0;
            found = 1'b0;
            for (int j = 0; j < count_b; j++) begin
              if (!found && list_b[j].row == list_a[i].row &&
                  list_b[j].col == list_a[i].col) begin
                add = list_b[j].value;
                found = 1'b1;
              end
            end
            sums[n] = '0;
            sums[n].entry.row = list_a[i].row;
            sums[n].entry.col = list_a[i].col;
            sums[n].entry.value = list_a[i].value + add;
            sums[n].overflowed = dropped;
            n++;
          end
          for (int i = 0; i < count_b; i++) begin
            found = 1'b0;
            for (int k = 0; k < n; k++) begin
              if (sums[k].entry.row == list_b[i].row && sums[k].entry.col == list_b[i].col)
                found = 1'b1;
            end
            if (!found) begin
              sums[n] = '0;
              sums[n].entry = list_b[i];
              sums[n].overflowed = dropped;
              n++;
            end
          end
          sums[n-1].is_last = 1'b1;
        end
        for (int k = 0; k < n; k++) pending_sums.push_back(sums[k]);
        count_a = 0;
        count_b = 0;
        dropped = 1'b0;
        n_runs++;
      end
      default: ;
    endcase
  endfunction

  task automatic push_beat(input logic [1:0] f, input logic [COORD_W-1:0] r,
                           input logic [COORD_W-1:0] c, input logic signed [VALUE_W-1:0] v);
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) @(negedge clk);
    in_func = f;
    in_row = r;
    in_col = c;
    in_value = v;
    push = 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_beat(f, r, c, v);
    if (f != FUNC_UNUSED) n_items++;
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic send_random_load(input logic [1:0] f);
    logic [COORD_W-1:0] r;
    logic [COORD_W-1:0] c;
    logic signed [VALUE_W-1:0] v;
    if ($urandom_range(0, 9) < 7) begin
      r = COORD_W'($urandom_range(0, 3));
      c = COORD_W'($urandom_range(0, 3));
    end else begin
      r = COORD_W'($urandom);
      c = COORD_W'($urandom);
    end
    v = $urandom;
    // cancel a recent A entry to get zero sums
    if (f == FUNC_LOAD_B && $urandom_range(0, 3) == 0) begin
      r = last_a.row;
      c = last_a.col;
      v = -last_a.value;
    end
    if (f == FUNC_LOAD_A) begin
      last_a.row = r;
      last_a.col = c;
      last_a.value = v;
    end
    push_beat(f, r, c, v);
  endtask

  task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                             input logic [VALUE_W-1:0] got);
    if (want !== got) begin
      $error("%s expected 0x%0h actual 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && pop && !empty) begin
      if (pending_sums.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = pending_sums.pop_front();
        check_field("out_row", VALUE_W'(want.entry.row), VALUE_W'(out_row));
        check_field("out_col", VALUE_W'(want.entry.col), VALUE_W'(out_col));
        check_field("out_value", want.entry.value, out_value);
        check_field("out_is_last", VALUE_W'(want.is_last), VALUE_W'(out_is_last));
        check_field("out_is_empty", VALUE_W'(want.is_empty), VALUE_W'(out_is_empty));
        check_field("out_overflowed", VALUE_W'(want.overflowed), VALUE_W'(out_overflowed));
        n_checked++;
      end
    end
  end

  // receiver stalls in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      pop = 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      pop = 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      pop = 1'b1;
    end
  end

  task automatic test_empty_run();
    push_beat(FUNC_RUN, 8'hff, 8'hff, 32'hffff_ffff);
    push_beat(FUNC_UNUSED, 8'h12, 8'h34, 32'h5678_9abc);
    push_beat(FUNC_RUN, '0, '0, '0);
  endtask

  task automatic test_extremes();
    push_beat(FUNC_LOAD_A, 8'h00, 8'h00, 32'sh7fff_ffff);
    push_beat(FUNC_LOAD_A, 8'hff, 8'hff, 32'sh8000_0000);
    push_beat(FUNC_LOAD_A, 8'haa, 8'h55, -32'sd1);
    push_beat(FUNC_LOAD_B, 8'h00, 8'h00, 32'sd1);
    push_beat(FUNC_LOAD_B, 8'hff, 8'hff, -32'sd1);
    push_beat(FUNC_LOAD_B, 8'h55, 8'haa, 32'sd0);
    push_beat(FUNC_RUN, '0, '0, '0);
  endtask

  task automatic test_zero_sum_and_repeats();
    push_beat(FUNC_LOAD_A, 8'd3, 8'd4, 32'sd5);
    push_beat(FUNC_LOAD_B, 8'd3, 8'd4, -32'sd5);
    push_beat(FUNC_LOAD_A, 8'd1, 8'd1, 32'sd10);
    push_beat(FUNC_LOAD_A, 8'd1, 8'd1, 32'sd20);
    push_beat(FUNC_LOAD_B, 8'd1, 8'd1, 32'sd7);
    push_beat(FUNC_LOAD_B, 8'd1, 8'd1, 32'sd9);
    push_beat(FUNC_LOAD_B, 8'd2, 8'd2, 32'sd100);
    push_beat(FUNC_LOAD_B, 8'd2, 8'd2, 32'sd1);
    push_beat(FUNC_RUN, '0, '0, '0);
    push_beat(FUNC_LOAD_B, 8'd9, 8'd9, 32'sd3);
    push_beat(FUNC_RUN, '0, '0, '0);
  endtask

  task automatic test_capacity();
    for (int i = 0; i < ENTRIES_DEF + 1; i++) send_random_load(FUNC_LOAD_A);
    send_random_load(FUNC_LOAD_B);
    send_random_load(FUNC_LOAD_B);
    push_beat(FUNC_RUN, '0, '0, '0);
    push_beat(FUNC_RUN, '0, '0, '0);
    for (int i = 0; i < ENTRIES_DEF + 2; i++) send_random_load(FUNC_LOAD_B);
    push_beat(FUNC_RUN, '0, '0, '0);
  endtask

  task automatic test_random_sums();
    int target;
    int kind;
    int left_a;
    int left_b;
    target = n_items + 50;
    while (n_items < target) begin
      if (n_items > target - 25) quiet = 1'b1;
      kind = $urandom_range(0, 11);
      if (kind == 0) begin
        push_beat(2'($urandom_range(0, 3)), COORD_W'($urandom), COORD_W'($urandom), $urandom);
      end else begin
        if (kind == 1) begin
          left_a = $urandom_range(12, ENTRIES_DEF + 1);
          left_b = $urandom_range(0, ENTRIES_DEF + 1);
        end else begin
          left_a = $urandom_range(0, 5);
          left_b = $urandom_range(0, 5);
        end
        while (left_a + left_b > 0) begin
          if (left_b == 0 || (left_a > 0 && $urandom_range(0, 1) == 0)) begin
            send_random_load(FUNC_LOAD_A);
            left_a--;
          end else begin
            send_random_load(FUNC_LOAD_B);
            left_b--;
          end
        end
        push_beat(FUNC_RUN, COORD_W'($urandom), COORD_W'($urandom), $urandom);
      end
    end
    push_beat(FUNC_RUN, '0, '0, '0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_empty_run();
    test_extremes();
    test_zero_sum_and_repeats();
    test_capacity();
    test_random_sums();
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("checked %0d result beats from %0d runs over %0d accepted loads and runs",
             n_checked, n_runs, n_items);
    $display("covered empty runs, wraparound, zero sums, repeated coordinates and dropped loads");
    if (errors == 0) $display("PASS sparse_matrix_coo_add");
    else $display("FAIL sparse_matrix_coo_add");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL sparse_matrix_coo_add");
    $finish;
  end

endmodule
